// ----- rtl/hppc_pkg.sv -----
// ----------------------------------------------------------------------------
// hppc_pkg: shared definitions for the heater PID power controller
// Field widths, margins, register map and request function codes.
// ----------------------------------------------------------------------------
package hppc_pkg;

  // Fixed-point scaling of the gains and of the accumulated power
  localparam int unsigned FRACTION_BITS = 11;

  // Field widths
  localparam int unsigned TEMP_W   = 12;
  localparam int unsigned GAIN_W   = 16;
  localparam int unsigned FIXED_W  = 10;
  localparam int unsigned POWER_W  = 11;
  localparam int unsigned ACC_W    = 32;
  localparam int unsigned FUNC_W   = 2;
  localparam int unsigned S_DATA_W = 16;
  localparam int unsigned M_DATA_W = 16;
  localparam int unsigned ADDR_W   = 5;
  localparam int unsigned DATA_W   = 32;

  // Control thresholds in ADC counts
  localparam int unsigned ITER_ERR_LIMIT = 120;
  localparam int unsigned SET_MARGIN     = 400;
  localparam int unsigned LIMIT_MARGIN   = 100;
  localparam int unsigned CLEAR_MARGIN   = 2;
  localparam int unsigned SETCHG_MARGIN  = 20;

  // Register reset values
  localparam logic [TEMP_W-1:0]  TEMP_LIMIT_RST = 12'd4095;
  localparam logic [GAIN_W-1:0]  GAIN_P_RST     = 16'd10;
  localparam logic [GAIN_W-1:0]  GAIN_I_RST     = 16'd10;
  localparam logic [POWER_W-1:0] POWER_CAP_RST  = 11'd1480;

  // Register map (index = paddr / 4)
  typedef enum logic [2:0] {
    REG_DRIVE_ON    = 3'd0,
    REG_SETPOINT    = 3'd1,
    REG_TEMP_LIMIT  = 3'd2,
    REG_GAIN_P      = 3'd3,
    REG_GAIN_I      = 3'd4,
    REG_GAIN_D      = 3'd5,
    REG_FIXED_POWER = 3'd6,
    REG_POWER_CAP   = 3'd7
  } reg_idx_e;

  // Request function codes; the remaining code is a no-op
  localparam logic [FUNC_W-1:0] FUNC_SAMPLE   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_RESTART  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_SETPOINT = 2'd2;

endpackage

// ----- rtl/heater_pid_power_controller.sv -----
// ----------------------------------------------------------------------------
// heater_pid_power_controller: heater drive from temperature readings
// Cooling lockout, direct PI start-up and incremental PID, rounded and clamped.
// ----------------------------------------------------------------------------
// Usage:
//  - s_axis carries one request: tdata = temp_reading, tuser = func
//    (sample, PID restart, setpoint changed). Each request gives one result.
//  - m_axis carries the result: tdata = drive_power, tuser = cooling.
//  - An APB port writes and reads the eight control registers at 4*index.
//    Write registers only while no request is in flight.
//  - A request accepted into the input register is computed combinationally;
//    its result is registered in the output register as it leaves.
//  - Throughput: one request per cycle while the receiver takes results. The
//    controller state (accumulators, previous readings, lockout flag) updates as
//    a request leaves the input register, so the next request sees the new state.
//  - The datapath between the registers holds three 32-bit-result multipliers
//    (P, I and D terms) feeding one accumulate, round and clamp.
//  - When the receiver stalls, the result is held; the input register still
//    takes one more request, then s_axis_tready drops until the result leaves.
//  - Reset clears the controller state and loads the registers' reset values.
// ----------------------------------------------------------------------------
module heater_pid_power_controller (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // request stream
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [hppc_pkg::S_DATA_W-1:0]   s_axis_tdata,  // [11:0] temp_reading
  input  logic [hppc_pkg::FUNC_W-1:0]     s_axis_tuser,  // [1:0] func
  // result stream
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [hppc_pkg::M_DATA_W-1:0]   m_axis_tdata,  // [10:0] drive_power
  output logic                            m_axis_tuser,  // [0] cooling
  // register port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [hppc_pkg::ADDR_W-1:0]     paddr,
  input  logic [hppc_pkg::DATA_W-1:0]     pwdata,
  output logic [hppc_pkg::DATA_W-1:0]     prdata,
  output logic                            pready
);

  localparam int unsigned TW = hppc_pkg::TEMP_W;
  localparam int unsigned AW = hppc_pkg::ACC_W;

  // Control registers
  logic                          drive_on_q;
  logic [TW-1:0]                 setpoint_q;
  logic [TW-1:0]                 temp_limit_q;
  logic [hppc_pkg::GAIN_W-1:0]   gain_p_q;
  logic [hppc_pkg::GAIN_W-1:0]   gain_i_q;
  logic [hppc_pkg::GAIN_W-1:0]   gain_d_q;
  logic [hppc_pkg::FIXED_W-1:0]  fixed_power_q;
  logic [hppc_pkg::POWER_W-1:0]  power_cap_q;
  logic                          cfg_wr;
  hppc_pkg::reg_idx_e            cfg_idx;

  // Input register
  logic                          in_valid_q;
  logic [hppc_pkg::FUNC_W-1:0]   func_q;
  logic [TW-1:0]                 temp_q;
  logic                          fire;

  // Controller state
  logic [TW-1:0]  prev_older_q, prev_older_d;
  logic [TW-1:0]  prev_temp_q, prev_temp_d;
  logic           iterating_q, iterating_d;
  logic [AW-1:0]  error_sum_q, error_sum_d;
  logic [AW-1:0]  power_acc_q, power_acc_d;
  logic           cooling_q, cooling_d;

  // Output register
  logic                          out_valid_q;
  logic [hppc_pkg::POWER_W-1:0]  out_power_q, out_power_d;
  logic                          out_cool_q, out_cool_d;

  // Datapath
  logic                  is_sample_on;
  logic                  trip, cool_set, cool_clear;
  logic [TW-1:0]         w_older, w_prev;
  logic                  w_iter;
  logic [AW-1:0]         w_sum, w_acc;
  logic signed [TW:0]    err, dtemp;
  logic signed [TW+2:0]  d2temp;
  logic                  direct, start_iter, iter_new;
  logic [AW-1:0]         sum_new;
  logic signed [TW:0]    op_p;
  logic signed [AW-1:0]  op_i;
  logic signed [AW-1:0]  prod_p, prod_i, prod_d;
  logic [AW-1:0]         acc_base, acc_new, rounded, shifted;
  logic [hppc_pkg::POWER_W-1:0] pid_power;

  // --------------------------------------------------------------------------
  // Register port
  // --------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_idx = hppc_pkg::reg_idx_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drive_on_q    <= 1'b0;
      setpoint_q    <= '0;
      temp_limit_q  <= hppc_pkg::TEMP_LIMIT_RST;
      gain_p_q      <= hppc_pkg::GAIN_P_RST;
      gain_i_q      <= hppc_pkg::GAIN_I_RST;
      gain_d_q      <= '0;
      fixed_power_q <= '0;
      power_cap_q   <= hppc_pkg::POWER_CAP_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        hppc_pkg::REG_DRIVE_ON:    drive_on_q    <= pwdata[0];
        hppc_pkg::REG_SETPOINT:    setpoint_q    <= pwdata[TW-1:0];
        hppc_pkg::REG_TEMP_LIMIT:  temp_limit_q  <= pwdata[TW-1:0];
        hppc_pkg::REG_GAIN_P:      gain_p_q      <= pwdata[hppc_pkg::GAIN_W-1:0];
        hppc_pkg::REG_GAIN_I:      gain_i_q      <= pwdata[hppc_pkg::GAIN_W-1:0];
        hppc_pkg::REG_GAIN_D:      gain_d_q      <= pwdata[hppc_pkg::GAIN_W-1:0];
        hppc_pkg::REG_FIXED_POWER: fixed_power_q <= pwdata[hppc_pkg::FIXED_W-1:0];
        hppc_pkg::REG_POWER_CAP:   power_cap_q   <= pwdata[hppc_pkg::POWER_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back the addressed register
  always_comb begin
    prdata = '0;
    case (cfg_idx)
      hppc_pkg::REG_DRIVE_ON:    prdata = {31'd0, drive_on_q};
      hppc_pkg::REG_SETPOINT:    prdata = 32'(setpoint_q);
      hppc_pkg::REG_TEMP_LIMIT:  prdata = 32'(temp_limit_q);
      hppc_pkg::REG_GAIN_P:      prdata = 32'(gain_p_q);
      hppc_pkg::REG_GAIN_I:      prdata = 32'(gain_i_q);
      hppc_pkg::REG_GAIN_D:      prdata = 32'(gain_d_q);
      hppc_pkg::REG_FIXED_POWER: prdata = 32'(fixed_power_q);
      hppc_pkg::REG_POWER_CAP:   prdata = 32'(power_cap_q);
      default:                   prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Handshake: advance the input register when the output register is free
  // --------------------------------------------------------------------------
  assign fire          = in_valid_q & (~out_valid_q | m_axis_tready);
  assign s_axis_tready = ~in_valid_q | fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid_q <= 1'b1;
    end else if (fire) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      func_q <= s_axis_tuser;
      temp_q <= s_axis_tdata[TW-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // Cooling lockout: trip on overheat, clear below setpoint minus margin
  // --------------------------------------------------------------------------
  assign is_sample_on = (func_q == hppc_pkg::FUNC_SAMPLE) & drive_on_q;
  assign trip = ({1'b0, temp_q} >= {1'b0, temp_limit_q} + 13'(hppc_pkg::LIMIT_MARGIN))
              | ({1'b0, temp_q} >  {1'b0, setpoint_q} + 13'(hppc_pkg::SET_MARGIN));
  assign cool_set   = cooling_q | trip;
  assign cool_clear = cool_set &
                      ({1'b0, temp_q} + 13'(hppc_pkg::CLEAR_MARGIN) < {1'b0, setpoint_q});

  // Clearing the lockout restarts the PID before this sample runs
  always_comb begin
    if (is_sample_on && cool_clear) begin
      w_older = '0;
      w_prev  = '0;
      w_iter  = 1'b0;
      w_sum   = '0;
      w_acc   = '0;
    end else begin
      w_older = prev_older_q;
      w_prev  = prev_temp_q;
      w_iter  = iterating_q;
      w_sum   = error_sum_q;
      w_acc   = power_acc_q;
    end
  end

  // --------------------------------------------------------------------------
  // PID terms: the P and I multipliers are shared between the two forms
  // --------------------------------------------------------------------------
  assign err    = $signed({1'b0, setpoint_q}) - $signed({1'b0, temp_q});
  assign dtemp  = $signed({1'b0, w_prev}) - $signed({1'b0, temp_q});
  assign d2temp = $signed({3'b000, w_older}) + $signed({3'b000, temp_q})
                - $signed({2'b00, w_prev, 1'b0});

  assign direct     = (w_older == '0);
  assign start_iter = direct & (err < $signed(13'(hppc_pkg::ITER_ERR_LIMIT))) & ~w_iter;
  assign iter_new   = w_iter | start_iter;
  assign acc_base   = start_iter ? '0 : w_acc;
  assign sum_new    = (start_iter ? '0 : w_sum) + {{(AW-TW-1){err[TW]}}, err};

  assign op_p = direct ? err : dtemp;
  assign op_i = direct ? $signed(sum_new) : $signed({{(AW-TW-1){err[TW]}}, err});

  assign prod_p = $signed({1'b0, gain_p_q}) * op_p;
  assign prod_i = $signed({1'b0, gain_i_q}) * op_i;
  assign prod_d = $signed({1'b0, gain_d_q}) * d2temp;

  assign acc_new = direct ? (prod_p + prod_i)
                          : (acc_base + prod_p + prod_i + prod_d);

  // Round, drop negatives and clamp to the power cap
  assign rounded = acc_new + (AW'(1) << (hppc_pkg::FRACTION_BITS - 1));
  assign shifted = rounded >> hppc_pkg::FRACTION_BITS;

  always_comb begin
    if (rounded[AW-1]) begin
      pid_power = '0;
    end else if (shifted > AW'(power_cap_q)) begin
      pid_power = power_cap_q;
    end else begin
      pid_power = shifted[hppc_pkg::POWER_W-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // Next state and result per request function
  // --------------------------------------------------------------------------
  always_comb begin
    prev_older_d = prev_older_q;
    prev_temp_d  = prev_temp_q;
    iterating_d  = iterating_q;
    error_sum_d  = error_sum_q;
    power_acc_d  = power_acc_q;
    cooling_d    = cooling_q;
    out_power_d  = '0;
    out_cool_d   = cooling_q;
    case (func_q)
      hppc_pkg::FUNC_SAMPLE: begin
        if (drive_on_q) begin
          cooling_d = cool_set & ~cool_clear;
          if (cool_set && !cool_clear) begin
            // lockout holds; power stays zero
            out_power_d = '0;
          end else begin
            prev_older_d = iter_new ? w_prev : w_older;
            prev_temp_d  = temp_q;
            iterating_d  = iter_new;
            error_sum_d  = direct ? sum_new : w_sum;
            power_acc_d  = acc_new;
            out_power_d  = pid_power;
          end
          out_cool_d = cooling_d;
        end else begin
          out_power_d = hppc_pkg::POWER_W'(fixed_power_q);
          out_cool_d  = 1'b0;
        end
      end
      hppc_pkg::FUNC_RESTART: begin
        prev_older_d = '0;
        prev_temp_d  = temp_q;
        iterating_d  = 1'b0;
        error_sum_d  = '0;
        power_acc_d  = '0;
      end
      hppc_pkg::FUNC_SETPOINT: begin
        if (drive_on_q) begin
          prev_older_d = '0;
          prev_temp_d  = temp_q;
          iterating_d  = 1'b0;
          error_sum_d  = '0;
          power_acc_d  = '0;
        end
        cooling_d  = ({1'b0, temp_q} > {1'b0, setpoint_q} + 13'(hppc_pkg::SETCHG_MARGIN));
        out_cool_d = cooling_d;
      end
      default: ;
    endcase
  end

  // Commit state as the request leaves the input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_older_q <= '0;
      prev_temp_q  <= '0;
      iterating_q  <= 1'b0;
      error_sum_q  <= '0;
      power_acc_q  <= '0;
      cooling_q    <= 1'b0;
    end else if (fire) begin
      prev_older_q <= prev_older_d;
      prev_temp_q  <= prev_temp_d;
      iterating_q  <= iterating_d;
      error_sum_q  <= error_sum_d;
      power_acc_q  <= power_acc_d;
      cooling_q    <= cooling_d;
    end
  end

  // --------------------------------------------------------------------------
  // Output register: hold the result until taken
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_power_q <= out_power_d;
      out_cool_q  <= out_cool_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = hppc_pkg::M_DATA_W'(out_power_q);
  assign m_axis_tuser  = out_cool_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // A result that reports cooling never drives the heater
  a_cool_no_power: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_cool_q) |-> (out_power_q == '0))
    else $error("cooling result carries nonzero power");

  // An older sample is only held in the incremental form
  a_older_iter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (prev_older_q != '0) |-> iterating_q)
    else $error("older sample held while not iterating");

  // Every request leaving the input register lands in the output register
  a_fire_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_valid_q)
    else $error("processed request lost");

  // The lockout only sets when a request is processed
  a_cool_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(cooling_q) |-> $past(fire))
    else $error("lockout set without a request");

  // A stalled result blocks the input register
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready) |=> ($stable(power_acc_q) && $stable(error_sum_q)))
    else $error("state changed while result stalled");

endmodule
